FILE: sv/variable_bin_weighted_histogram_top_defines.svh
// assertion macros shared by the histogram checker
`ifndef VARIABLE_BIN_WEIGHTED_HISTOGRAM_TOP_DEFINES_SVH
`define VARIABLE_BIN_WEIGHTED_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication
`define VBWH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// next-cycle implication
`define VBWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`endif

FILE: sv/vbwh_pkg.sv
// types and constants of the variable-bin weighted histogram
`default_nettype none

package vbwh_pkg;

    localparam int MAX_EDGES = 64;
    localparam int NBINS     = MAX_EDGES - 1;
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int BIN_AW    = $clog2(NBINS);
    localparam int SLOT_W    = $clog2(MAX_EDGES) + 1;
    localparam int CFG_W     = $clog2(MAX_EDGES + 1);
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 48;
    localparam int SQ_W      = 64;
    localparam int BIN_W     = SUM_W + SQ_W;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_UNDER = SLOT_W'(MAX_EDGES - 1);
    localparam logic [SLOT_W-1:0] SLOT_OVER  = SLOT_W'(MAX_EDGES);

    localparam logic [CFG_W-1:0] EDGES_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] EDGES_MAX   = CFG_W'(MAX_EDGES);
    localparam logic [CFG_W-1:0] EDGES_RESET = CFG_W'(2);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]              action;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] event_weight;
    } t_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [BIN_AW-1:0]       bin_found;
        logic signed [SUM_W-1:0] content_sum;
        logic [SQ_W-1:0]         square_sum;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/vbwh_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module vbwh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/variable_bin_weighted_histogram_top.sv
// weighted histogram with loadable, variable bin edges and saturating sums
//
// usage
// - command channel: an item (action, slot, value, event_weight) is taken at a
//   rising edge with start high and busy low; busy then stays high until the
//   result is produced
// - result channel: o_done pulses for one cycle with o_result; the receiver
//   cannot stall it, so it must take the item in that cycle
// - config channel: edges_in_use is written through i_cfg_valid/o_cfg_ready;
//   ready is high only while the block is idle
// - states from the accepting edge to the o_done cycle:
//   load edge, clear: S_LOAD or S_CLEAR; read: S_READ, then S_RDW for an in-range bin
//   fill: S_E0, S_EL (underflow ends here), S_ECHK (overflow ends here), then
//   S_SCAN over any inner edges of the clamped edge count (2..64), and S_BRD
// - fill cost is set by one signed comparator that walks the edge memory one
//   edge per cycle, then one read-modify-write of the bin memory
// - busy falls in the o_done cycle, so the next item may start right then
// - reset: edge count 2, all sums zero, edge table undefined until loaded;
//   bin sums are cleared at once through per-bin valid flags (no sweep)
`default_nettype none

module variable_bin_weighted_histogram_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire vbwh_pkg::t_item               i_item,
    // result channel
    output logic                               o_done,
    output vbwh_pkg::t_result                  o_result,
    // config channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vbwh_pkg::CFG_W-1:0]    i_cfg_data
);

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOAD  = 10'b00_0000_0010,
        S_CLEAR = 10'b00_0000_0100,
        S_READ  = 10'b00_0000_1000,
        S_RDW   = 10'b00_0001_0000,
        S_E0    = 10'b00_0010_0000,
        S_EL    = 10'b00_0100_0000,
        S_ECHK  = 10'b00_1000_0000,
        S_SCAN  = 10'b01_0000_0000,
        S_BRD   = 10'b10_0000_0000
    } t_state;

    // saturating signed add into the 48-bit sums
    function automatic logic signed [vbwh_pkg::SUM_W-1:0] sat_add48(
        input logic signed [vbwh_pkg::SUM_W-1:0] acc,
        input logic signed [vbwh_pkg::VAL_W-1:0] w
    );
        logic signed [vbwh_pkg::SUM_W:0] s;
        s = (vbwh_pkg::SUM_W+1)'(acc) + (vbwh_pkg::SUM_W+1)'(w);
        if (s[vbwh_pkg::SUM_W] != s[vbwh_pkg::SUM_W-1]) begin
            return s[vbwh_pkg::SUM_W] ? vbwh_pkg::SUM_MIN : vbwh_pkg::SUM_MAX;
        end
        return s[vbwh_pkg::SUM_W-1:0];
    endfunction

    // saturating unsigned add into the square sums
    function automatic logic [vbwh_pkg::SQ_W-1:0] sat_addu64(
        input logic [vbwh_pkg::SQ_W-1:0] acc,
        input logic [vbwh_pkg::SQ_W-1:0] x
    );
        logic [vbwh_pkg::SQ_W:0] s;
        s = {1'b0, acc} + {1'b0, x};
        return s[vbwh_pkg::SQ_W] ? {vbwh_pkg::SQ_W{1'b1}} : s[vbwh_pkg::SQ_W-1:0];
    endfunction

    // control state
    t_state                               r_state, n_state;
    logic                                 r_done, n_done;
    logic [vbwh_pkg::CFG_W-1:0]           r_edges, n_edges;
    logic signed [vbwh_pkg::SUM_W-1:0]    r_under, n_under;
    logic signed [vbwh_pkg::SUM_W-1:0]    r_over, n_over;
    logic [vbwh_pkg::NBINS-1:0]           r_valid, n_valid;
    // payload and working registers
    vbwh_pkg::t_item                      r_item, n_item;
    vbwh_pkg::t_result                    r_result, n_result;
    logic [vbwh_pkg::SQ_W-1:0]            r_sq, n_sq;
    logic [vbwh_pkg::EDGE_AW-1:0]         r_idx, n_idx;
    logic [vbwh_pkg::BIN_AW-1:0]          r_cnt, n_cnt;
    logic [vbwh_pkg::BIN_AW-1:0]          r_bin, n_bin;

    // memory ports
    logic                                 e_we;
    logic [vbwh_pkg::EDGE_AW-1:0]         e_raddr;
    logic [vbwh_pkg::VAL_W-1:0]           e_rdata;
    logic                                 b_we;
    logic [vbwh_pkg::BIN_AW-1:0]          b_raddr;
    logic [vbwh_pkg::BIN_W-1:0]           b_wdata;
    logic [vbwh_pkg::BIN_W-1:0]           b_rdata;

    // datapath helpers
    logic                                 acc;
    logic [vbwh_pkg::CFG_W-1:0]           edge_use;
    logic [vbwh_pkg::CFG_W-1:0]           edge_m1;
    logic [vbwh_pkg::CFG_W-1:0]           edge_m2;
    logic                                 val_lt;
    logic [vbwh_pkg::BIN_AW-1:0]          cnt_next;
    logic [vbwh_pkg::VAL_W-1:0]           w_mag;
    logic signed [vbwh_pkg::SUM_W-1:0]    cur_c;
    logic [vbwh_pkg::SQ_W-1:0]            cur_s;
    logic signed [vbwh_pkg::SUM_W-1:0]    new_c;
    logic [vbwh_pkg::SQ_W-1:0]            new_s;

    assign acc         = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;

    // clamp the edge count to 2..MAX_EDGES
    always_comb begin
        if (r_edges < vbwh_pkg::EDGES_MIN) begin
            edge_use = vbwh_pkg::EDGES_MIN;
        end else if (r_edges > vbwh_pkg::EDGES_MAX) begin
            edge_use = vbwh_pkg::EDGES_MAX;
        end else begin
            edge_use = r_edges;
        end
    end

    assign edge_m1 = edge_use - vbwh_pkg::CFG_W'(1);
    assign edge_m2 = edge_use - vbwh_pkg::CFG_W'(2);

    // the shared comparator: energy against the edge just read
    assign val_lt   = r_item.value < $signed(e_rdata);
    assign cnt_next = r_cnt + vbwh_pkg::BIN_AW'(!val_lt);

    // magnitude of the weight; the most negative weight maps to 2^31
    assign w_mag = r_item.event_weight[vbwh_pkg::VAL_W-1]
                 ? (~r_item.event_weight + vbwh_pkg::VAL_W'(1))
                 : r_item.event_weight;

    // bin read data, zero for bins not written since the last clear
    assign cur_c = r_valid[r_bin] ? b_rdata[vbwh_pkg::BIN_W-1:vbwh_pkg::SQ_W] : '0;
    assign cur_s = r_valid[r_bin] ? b_rdata[vbwh_pkg::SQ_W-1:0] : '0;
    assign new_c = sat_add48(cur_c, r_item.event_weight);
    assign new_s = sat_addu64(cur_s, r_sq);

    // memory port control
    assign e_we    = (r_state == S_LOAD) && (r_item.slot < vbwh_pkg::SLOT_W'(vbwh_pkg::MAX_EDGES));
    assign b_we    = (r_state == S_BRD);
    assign b_wdata = {new_c, new_s};

    always_comb begin
        unique case (r_state)
            S_E0:    e_raddr = '0;
            S_EL:    e_raddr = edge_m1[vbwh_pkg::EDGE_AW-1:0];
            S_ECHK:  e_raddr = vbwh_pkg::EDGE_AW'(1);
            default: e_raddr = r_idx + vbwh_pkg::EDGE_AW'(1);
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_SCAN:  b_raddr = cnt_next;
            S_READ:  b_raddr = r_item.slot[vbwh_pkg::BIN_AW-1:0];
            default: b_raddr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_edges  = r_edges;
        n_under  = r_under;
        n_over   = r_over;
        n_valid  = r_valid;
        n_item   = r_item;
        n_result = r_result;
        n_sq     = r_sq;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_bin    = r_bin;

        if (i_cfg_valid && o_cfg_ready) begin
            n_edges = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_item = i_item;
                    unique case (i_item.action)
                        vbwh_pkg::ACT_LOAD:  n_state = S_LOAD;
                        vbwh_pkg::ACT_CLEAR: n_state = S_CLEAR;
                        vbwh_pkg::ACT_FILL:  n_state = S_E0;
                        vbwh_pkg::ACT_READ:  n_state = S_READ;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                // edge write happens on the ram port this cycle
                n_result        = '0;
                n_result.status = e_we ? vbwh_pkg::STAT_OK : vbwh_pkg::STAT_RANGE;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            S_CLEAR: begin
                n_valid  = '0;
                n_under  = '0;
                n_over   = '0;
                n_result = '0;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_READ: begin
                n_result = '0;
                n_bin    = r_item.slot[vbwh_pkg::BIN_AW-1:0];
                if (r_item.slot == vbwh_pkg::SLOT_UNDER) begin
                    n_result.content_sum = r_under;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_item.slot == vbwh_pkg::SLOT_OVER) begin
                    n_result.content_sum = r_over;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_item.slot < edge_m1) begin
                    n_state = S_RDW;
                end else begin
                    n_result.status = vbwh_pkg::STAT_RANGE;
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RDW: begin
                n_result             = '0;
                n_result.content_sum = cur_c;
                n_result.square_sum  = cur_s;
                n_done               = 1'b1;
                n_state              = S_IDLE;
            end
            S_E0: begin
                // first edge is being read; square the weight meanwhile
                n_sq    = vbwh_pkg::SQ_W'(w_mag) * vbwh_pkg::SQ_W'(w_mag);
                n_state = S_EL;
            end
            S_EL: begin
                if (val_lt) begin
                    n_under              = sat_add48(r_under, r_item.event_weight);
                    n_result             = '0;
                    n_result.status      = vbwh_pkg::STAT_UNDER;
                    n_result.content_sum = n_under;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                n_cnt = '0;
                n_idx = vbwh_pkg::EDGE_AW'(1);
                if (!val_lt) begin
                    n_over               = sat_add48(r_over, r_item.event_weight);
                    n_result             = '0;
                    n_result.status      = vbwh_pkg::STAT_OVER;
                    n_result.content_sum = n_over;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else if (edge_use == vbwh_pkg::EDGES_MIN) begin
                    // no inner edges: the only bin is bin 0
                    n_bin   = '0;
                    n_state = S_BRD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // count inner edges at or below the energy
                n_cnt = cnt_next;
                n_idx = r_idx + vbwh_pkg::EDGE_AW'(1);
                if (r_idx == edge_m2[vbwh_pkg::EDGE_AW-1:0]) begin
                    n_bin   = cnt_next;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                // read-modify-write of the bin; the write goes out on the ram port
                n_valid[r_bin]       = 1'b1;
                n_result             = '0;
                n_result.status      = vbwh_pkg::STAT_OK;
                n_result.bin_found   = r_bin;
                n_result.content_sum = new_c;
                n_result.square_sum  = new_s;
                n_done               = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_edges <= vbwh_pkg::EDGES_RESET;
            r_under <= '0;
            r_over  <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_edges <= n_edges;
            r_under <= n_under;
            r_over  <= n_over;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
        r_sq     <= n_sq;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_bin    <= n_bin;
    end

    // edge table
    vbwh_ram #(
        .WIDTH (vbwh_pkg::VAL_W),
        .DEPTH (vbwh_pkg::MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_item.slot[vbwh_pkg::EDGE_AW-1:0]),
        .i_wdata (r_item.value),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // bin content and square sums, one row per bin
    vbwh_ram #(
        .WIDTH (vbwh_pkg::BIN_W),
        .DEPTH (vbwh_pkg::NBINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_bin),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

endmodule

`default_nettype wire

FILE: sv/vbwh_checker.sv
// port-level checker for the histogram, bound to the top level
`default_nettype none

`include "variable_bin_weighted_histogram_top_defines.svh"

module vbwh_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire vbwh_pkg::t_result o_result
);

    `VBWH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    `VBWH_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    `VBWH_ASSERT_SAME(a_fell_done, i_clk, i_rst_n, $fell(busy), o_done)

    `VBWH_ASSERT_SAME(a_range_zero, i_clk, i_rst_n, o_done && o_result.status == vbwh_pkg::STAT_RANGE, o_result.bin_found == '0 && o_result.content_sum == '0 && o_result.square_sum == '0)

    `VBWH_ASSERT_SAME(a_edge_nosq, i_clk, i_rst_n, o_done && (o_result.status == vbwh_pkg::STAT_UNDER || o_result.status == vbwh_pkg::STAT_OVER), o_result.square_sum == '0 && o_result.bin_found == '0)

endmodule

bind variable_bin_weighted_histogram_top vbwh_checker u_vbwh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the variable-bin weighted histogram
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vbwh_pkg::*;

    // one row of the directed stimulus; typed rows carry their result inline
    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // shadow of the histogram state, advanced at every accepted item
    logic [CFG_W-1:0]        edge_count;
    logic signed [VAL_W-1:0] edge_copy [MAX_EDGES];
    logic signed [SUM_W-1:0] bin_sum [NBINS];
    logic [SQ_W-1:0]         bin_sq [NBINS];
    logic signed [SUM_W-1:0] under_sum;
    logic signed [SUM_W-1:0] over_sum;

    // ascending edge layout last loaded, used to repair edges after random loads
    int layout [MAX_EDGES];

    // directed rows, walked in order
    t_stim_row directed [$];
    // readouts owed by the block, oldest first
    t_result due_readouts [$];
    int      miscompares;
    // no random gaps while set
    bit      steady;

    variable_bin_weighted_histogram_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // edge count as the block uses it, clamped to [2, MAX_EDGES]
    function automatic int active_edges();
        if (edge_count < EDGES_MIN) return int'(EDGES_MIN);
        if (edge_count > EDGES_MAX) return int'(EDGES_MAX);
        return int'(edge_count);
    endfunction

    // signed 48-bit accumulate with clamping
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] acc,
                                                       input logic signed [VAL_W-1:0] w);
        longint total;
        total = longint'(acc) + longint'(w);
        if (total > longint'(SUM_MAX)) return SUM_MAX;
        if (total < longint'(SUM_MIN)) return SUM_MIN;
        return SUM_W'(total);
    endfunction

    // histogram behavior: updates the shadow state, returns the readout
    function automatic t_result histogram_predict(input t_item it);
        t_result           r;
        int                n;
        int                b;
        logic [SQ_W-1:0]   mag;
        logic [SQ_W:0]     sq_wide;
        r = '0;
        n = active_edges();
        case (it.action)
            ACT_LOAD: begin
                if (it.slot < MAX_EDGES) edge_copy[it.slot] = it.value;
                else r.status = STAT_RANGE;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < NBINS; i++) begin
                    bin_sum[i] = '0;
                    bin_sq[i] = '0;
                end
                under_sum = '0;
                over_sum = '0;
            end
            ACT_FILL: begin
                if (it.value < edge_copy[0]) begin
                    under_sum = sat_sum(under_sum, it.event_weight);
                    r.status = STAT_UNDER;
                    r.content_sum = under_sum;
                end else if (it.value >= edge_copy[n-1]) begin
                    over_sum = sat_sum(over_sum, it.event_weight);
                    r.status = STAT_OVER;
                    r.content_sum = over_sum;
                end else begin
                    // count of inner edges at or below the value; the bin when edges ascend
                    b = 0;
                    for (int i = 1; i + 1 < n; i++)
                        if (edge_copy[i] <= it.value) b++;
                    mag = (it.event_weight < 0) ? SQ_W'(-longint'(it.event_weight))
                                                : SQ_W'(longint'(it.event_weight));
                    bin_sum[b] = sat_sum(bin_sum[b], it.event_weight);
                    sq_wide = {1'b0, bin_sq[b]} + {1'b0, mag * mag};
                    bin_sq[b] = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
                    r.bin_found = BIN_AW'(b);
                    r.content_sum = bin_sum[b];
                    r.square_sum = bin_sq[b];
                end
            end
            default: begin
                if (it.slot == SLOT_UNDER) r.content_sum = under_sum;
                else if (it.slot == SLOT_OVER) r.content_sum = over_sum;
                else if (it.slot < n - 1) begin
                    r.content_sum = bin_sum[it.slot];
                    r.square_sum = bin_sq[it.slot];
                end else r.status = STAT_RANGE;
            end
        endcase
        return r;
    endfunction

    function automatic t_stim_row plain(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                                        input logic [VAL_W-1:0] value,
                                        input logic [VAL_W-1:0] weight);
        t_stim_row s;
        s.it.action = act;
        s.it.slot = slot;
        s.it.value = value;
        s.it.event_weight = weight;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    // row with a result known at a glance (bin 0, no square sum)
    function automatic t_stim_row known(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                                        input logic [VAL_W-1:0] value,
                                        input logic [VAL_W-1:0] weight,
                                        input logic [1:0] status,
                                        input logic [SUM_W-1:0] content);
        t_stim_row s;
        s = plain(act, slot, value, weight);
        s.typed = 1'b1;
        s.want.status = status;
        s.want.content_sum = content;
        return s;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_stim_row s);
        directed.insert(directed.size(), s);
    endfunction

    // drive one item from a falling edge, hold until taken, log its readout
    task automatic issue(input t_stim_row s);
        t_result pred;
        if (!steady && $urandom_range(0, 99) < 6) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = s.it;
        do @(posedge i_clk); while (busy);
        pred = histogram_predict(s.it);
        due_readouts.insert(due_readouts.size(), s.typed ? s.want : pred);
        @(negedge i_clk);
    endtask

    // write edges_in_use once the block has drained
    task automatic set_edge_count(input logic [CFG_W-1:0] count);
        start = 1'b0;
        while (due_readouts.size() != 0) @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < 6)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = count;
        do @(posedge i_clk); while (!o_cfg_ready);
        edge_count = count;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // well-formed setup: every edge in use loaded, ascending
    task automatic load_layout(input int n);
        int pos;
        pos = -int'($urandom_range(0, 32'h4000_0000));
        for (int k = 0; k < n; k++) begin
            layout[k] = pos;
            issue(plain(ACT_LOAD, SLOT_W'(k), pos, $urandom));
            pos += ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4))
                                               : int'($urandom_range(1, 32'h0100_0000));
        end
    endtask

    function automatic logic [VAL_W-1:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4, 5: return ($urandom_range(0, 1) ? 32'd1 : -32'd1) * $urandom_range(0, 32'h3_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // mostly fills and reads around the loaded edges, some loads and clears
    function automatic t_stim_row random_row(input int n);
        t_stim_row s;
        int        sel;
        int        k;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, n - 1);
        s = plain(ACT_FILL, SLOT_W'($urandom), $urandom, random_weight());
        if (sel < 50) begin
            case ($urandom_range(0, 4))
                0: s.it.value = edge_copy[k];
                1: s.it.value = edge_copy[k] - 1;
                2: s.it.value = edge_copy[k] + 1;
                3: s.it.value = edge_copy[k] + $urandom_range(0, 255);
                default: ;
            endcase
        end else if (sel < 75) begin
            s.it.action = ACT_READ;
            case ($urandom_range(0, 4))
                0, 1: s.it.slot = SLOT_W'($urandom_range(0, n - 1));
                2:    s.it.slot = SLOT_UNDER;
                3:    s.it.slot = SLOT_OVER;
                default: ;
            endcase
        end else if (sel < 96) begin
            s.it.action = ACT_LOAD;
            if ($urandom_range(0, 4) != 0) s.it.slot = SLOT_W'($urandom_range(0, n - 1));
            // half the loads restore the ascending layout, half scramble it
            if (s.it.slot < MAX_EDGES && $urandom_range(0, 1)) s.it.value = layout[s.it.slot];
        end else begin
            s.it.action = ACT_CLEAR;
        end
        return s;
    endfunction

    // readout checker: every strobe against the oldest owed readout
    always @(posedge i_clk) begin : readout_check
        t_result want;
        string   bad;
        if (i_rst_n && o_done) begin
            if (due_readouts.size() == 0) begin
                miscompares++;
                if (miscompares <= 10)
                    $display("unexpected readout: status %0d bin %0d content %0d square %h",
                             o_result.status, o_result.bin_found, o_result.content_sum,
                             o_result.square_sum);
            end else begin
                want = due_readouts.pop_front();
                bad = "";
                if (o_result.status !== want.status) bad = {bad, " status"};
                if (o_result.bin_found !== want.bin_found) bad = {bad, " bin_found"};
                if (o_result.content_sum !== want.content_sum) bad = {bad, " content_sum"};
                if (o_result.square_sum !== want.square_sum) bad = {bad, " square_sum"};
                if (bad != "") begin
                    miscompares++;
                    if (miscompares <= 10)
                        $display("%0t mismatch in%s: want %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                                 $realtime, bad, want.status, want.bin_found, want.content_sum,
                                 want.square_sum, o_result.status, o_result.bin_found,
                                 o_result.content_sum, o_result.square_sum);
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] counts [8];
        int               n;

        // every input known from time zero, reset asserted from the start
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = EDGES_RESET;
        i_rst_n = 1'b0;
        steady = 1'b0;
        miscompares = 0;
        edge_count = EDGES_RESET;
        for (int i = 0; i < MAX_EDGES; i++) edge_copy[i] = '0;
        for (int i = 0; i < NBINS; i++) begin
            bin_sum[i] = '0;
            bin_sq[i] = '0;
        end
        under_sum = '0;
        over_sum = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: sums read as zero, one bin in use
        add_row(known(ACT_READ, 7'd0, 0, 0, STAT_OK, '0));
        add_row(known(ACT_READ, SLOT_UNDER, 0, 0, STAT_OK, '0));
        add_row(known(ACT_READ, SLOT_OVER, 0, 0, STAT_OK, '0));
        // bin slot past the edges in use and slot past the overflow slot
        add_row(known(ACT_READ, 7'd1, 0, 0, STAT_RANGE, '0));
        add_row(known(ACT_READ, 7'h7F, 0, 0, STAT_RANGE, '0));
        // loads beyond the table write nothing
        add_row(known(ACT_LOAD, SLOT_OVER, 32'h1234_5678, 0, STAT_RANGE, '0));
        add_row(known(ACT_LOAD, 7'h7F, 32'hFFFF_FFFF, 0, STAT_RANGE, '0));
        // edges 0.0 and 1.0 give a single bin [0, 1)
        add_row(known(ACT_LOAD, 7'd0, 32'h0000_0000, 0, STAT_OK, '0));
        add_row(known(ACT_LOAD, 7'd1, 32'h0001_0000, 0, STAT_OK, '0));
        // most negative energy underflows, most positive overflows
        add_row(known(ACT_FILL, 7'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                      STAT_UNDER, 48'h0000_7FFF_FFFF));
        add_row(known(ACT_FILL, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                      STAT_OVER, 48'hFFFF_8000_0000));
        // four fills of the most negative weight on the first edge: square sum clamps
        repeat (4) add_row(plain(ACT_FILL, 7'd0, 32'h0000_0000, 32'h8000_0000));
        // just below the last edge stays in range, on it overflows, just below edge 0 underflows
        add_row(plain(ACT_FILL, 7'd0, 32'h0000_FFFF, 32'h0000_0001));
        add_row(plain(ACT_FILL, 7'd0, 32'h0001_0000, 32'h0000_0005));
        add_row(plain(ACT_FILL, 7'd0, 32'hFFFF_FFFF, 32'h0000_0007));
        add_row(plain(ACT_READ, 7'd0, 0, 0));
        add_row(plain(ACT_READ, SLOT_UNDER, 0, 0));
        add_row(plain(ACT_READ, SLOT_OVER, 0, 0));
        // clear wipes every sum
        add_row(known(ACT_CLEAR, 7'd0, 0, 0, STAT_OK, '0));
        add_row(known(ACT_READ, 7'd0, 0, 0, STAT_OK, '0));
        add_row(known(ACT_READ, SLOT_OVER, 0, 0, STAT_OK, '0));

        foreach (directed[i]) issue(directed[i]);

        // edge count settings: full table, below minimum, small, above maximum, odd sizes, random, minimum
        counts = '{EDGES_MAX, 7'd0, 7'd5, 7'h7F, 7'd1, 7'd33,
                   CFG_W'($urandom_range(2, 64)), EDGES_MIN};
        foreach (counts[p]) begin
            set_edge_count(counts[p]);
            n = active_edges();
            // one phase runs back to back with no gaps
            steady = (p == 2);
            load_layout(n);
            repeat (22) issue(random_row(n));
        end
        steady = 1'b0;
        start = 1'b0;

        // drain, then allow for the longest fill latency
        while (due_readouts.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (miscompares == 0 && due_readouts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
